// ===== rtl/sdi_pkg.sv =====
// Package: constants, command tables and CRC7 helper for the SD SPI init sequencer.
`timescale 1ns / 1ps
package sdi_pkg;

  localparam int unsigned PollCountBits = 20;

  localparam logic [5:0] PhIdle    = 6'd0;
  localparam logic [5:0] PhWake    = 6'd1;
  localparam logic [5:0] PhTail    = 6'd2;
  localparam logic [5:0] PhOk      = 6'd3;
  localparam logic [5:0] PhErr     = 6'd4;
  localparam logic [5:0] PhCmdBase = 6'd8;

  localparam logic [3:0] NumCmds  = 4'd11;
  localparam logic [3:0] CGoIdle  = 4'd0;
  localparam logic [3:0] CIfCond  = 4'd1;
  localparam logic [3:0] COcrV1   = 4'd2;
  localparam logic [3:0] CAppV1   = 4'd3;
  localparam logic [3:0] COpV1    = 4'd4;
  localparam logic [3:0] COcrV2   = 4'd5;
  localparam logic [3:0] CCrcOn   = 4'd6;
  localparam logic [3:0] CAppV2   = 4'd7;
  localparam logic [3:0] COpV2    = 4'd8;
  localparam logic [3:0] CCrcOff  = 4'd9;
  localparam logic [3:0] CCcs     = 4'd10;

  localparam logic OpStart    = 1'b0;
  localparam logic OpExchange = 1'b1;

  localparam logic [0:0] RegReplyWait = 1'd0;
  localparam logic [0:0] RegWakeup    = 1'd1;

  localparam logic [7:0] CrcPoly = 8'h12;

  function automatic logic [7:0] cmd_code(input logic [3:0] c);
    case (c)
      CGoIdle:                 cmd_code = 8'h40;
      CIfCond:                 cmd_code = 8'h48;
      COcrV1, COcrV2, CCcs:    cmd_code = 8'h7A;
      CAppV1, CAppV2:          cmd_code = 8'h77;
      COpV1, COpV2:            cmd_code = 8'h69;
      CCrcOn, CCrcOff:         cmd_code = 8'h7B;
      default:                 cmd_code = 8'h00;
    endcase
  endfunction

  function automatic logic [31:0] cmd_arg(input logic [3:0] c);
    case (c)
      CIfCond: cmd_arg = 32'h0000_01AA;
      CCrcOn:  cmd_arg = 32'h0000_0001;
      COpV2:   cmd_arg = 32'h4000_0000;
      default: cmd_arg = 32'h0;
    endcase
  endfunction

  function automatic logic cmd_crc(input logic [3:0] c);
    cmd_crc = (c == CGoIdle) || (c == CIfCond) || (c == CAppV2) ||
              (c == COpV2) || (c == CCrcOff);
  endfunction

  function automatic logic [2:0] cmd_data(input logic [3:0] c);
    case (c)
      CIfCond:               cmd_data = 3'd5;
      COcrV1, COcrV2, CCcs:  cmd_data = 3'd4;
      default:               cmd_data = 3'd0;
    endcase
  endfunction

  // Bitwise CRC7 update over one byte, MSB first (eight narrow steps)
  function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    logic       top;
    c = crc;
    for (int b = 7; b >= 0; b--) begin
      top = c[7];
      c = {c[6:0], 1'b0};
      if (v[b] != top) c = c ^ CrcPoly;
    end
    crc7_byte = c;
  endfunction

endpackage

// ===== rtl/sd_spi_card_init_sequencer.sv =====
// Top level: SD card SPI-mode start-up sequencer, one byte exchange per beat.
`timescale 1ns / 1ps
// One input beat (start or completed exchange) yields one result beat holding
// the next byte to send and the status flags. The next state and result are
// computed combinationally from the registered sequencer state; the result sits
// in an output register, and a new beat is accepted every cycle while that
// register is empty or being drained (sustained rate: 1 beat per cycle).
module sd_spi_card_init_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_valid_o,
  output logic        finished_o,
  output logic        init_status_o,
  output logic        card_v2_o,
  output logic        block_addressing_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import sdi_pkg::*;

  logic [19:0] wait_lim_q;
  logic [7:0]  wake_cnt_cfg_q;
  logic [5:0]  phase_q, phase_d;
  logic [2:0]  fbi_q, fbi_d;
  logic [PollCountBits-1:0] poll_q, poll_d;
  logic [7:0]  wake_q, wake_d;
  logic [31:0] word_q, word_d;
  logic [7:0]  rstat_q, rstat_d;
  logic [7:0]  crc_q, crc_d;
  logic        ver_q, ver_d, addr_q, addr_d;
  logic        ovalid_q;
  logic [7:0]  tx_q;
  logic        txv_q;

  logic accept;
  assign in_ready_o  = !ovalid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Next-state logic for one beat
  logic [8:0] nxt;
  always_comb begin
    logic [3:0] cmd, rc;
    logic [1:0] stg;
    logic [7:0] r, b, wk;
    logic [31:0] w;
    logic r01, volt, res, found;
    logic [2:0] fi;
    phase_d = phase_q; fbi_d = fbi_q; poll_d = poll_q; wake_d = wake_q;
    word_d = word_q; rstat_d = rstat_q; crc_d = crc_q; ver_d = ver_q; addr_d = addr_q;
    nxt = 9'h100; res = 1'b0; rc = CGoIdle; b = 8'h00; wk = 8'h00; fi = 3'd0;
    r01 = 1'b0; volt = 1'b0;
    cmd = 4'((phase_q - PhCmdBase) >> 2);
    stg = 2'(phase_q - PhCmdBase);
    r = rstat_q; w = word_q;
    found = !rx_byte_i[7];
    if (operation_i == OpStart) begin
      phase_d = PhWake; wake_d = 8'd0; fbi_d = 3'd0; poll_d = '0;
      word_d = 32'd0; rstat_d = 8'hFF; crc_d = 8'd0; nxt = 9'h0FF;
    end else if (phase_q == PhWake) begin
      wk = wake_q + 8'd1;
      wake_d = wk;
      if (wk < wake_cnt_cfg_q) nxt = 9'h0FF;
      else begin rc = CGoIdle; res = 1'b1; end
    end else if (phase_q == PhTail) begin
      phase_d = PhOk;
    end else if (phase_q < PhCmdBase) begin
      nxt = 9'h100;
    end else if (cmd >= NumCmds || stg > 2'd2) begin
      phase_d = PhIdle;
    end else if (stg == 2'd0) begin
      if (fbi_q < 3'd6) begin
        fi = fbi_q + 3'd1;
        fbi_d = fi;
        case (fi)
          3'd1:    b = cmd_code(cmd);
          3'd2:    b = cmd_arg(cmd)[31:24];
          3'd3:    b = cmd_arg(cmd)[23:16];
          3'd4:    b = cmd_arg(cmd)[15:8];
          3'd5:    b = cmd_arg(cmd)[7:0];
          default: b = cmd_crc(cmd) ? (crc_q | 8'h01) : 8'hFF;
        endcase
        if (fi <= 3'd5) crc_d = crc7_byte(crc_q, b);
        nxt = {1'b0, b};
      end else begin
        phase_d = phase_q + 6'd1; poll_d = '0; word_d = 32'd0; nxt = 9'h0FF;
      end
    end else if (stg == 2'd1) begin
      if (!found && poll_q < wait_lim_q[PollCountBits-1:0]) begin
        poll_d = poll_q + 1'b1; nxt = 9'h0FF;
      end else begin
        rstat_d = rx_byte_i; r = rx_byte_i;
        if (found && cmd_data(cmd) != 3'd0) begin
          phase_d = phase_q + 6'd1; fbi_d = 3'd0; nxt = 9'h0FF;
        end else res = 1'b1;
      end
    end else begin
      if (fbi_q < 3'd4) begin word_d = {word_q[23:0], rx_byte_i}; w = word_d; end
      fi = fbi_q + 3'd1;
      fbi_d = fi;
      if (fi >= cmd_data(cmd)) res = 1'b1;
      else nxt = 9'h0FF;
    end
    // Reply resolution: pick the next command or end the sequence
    if (res && !(phase_q == PhWake)) begin
      r01 = (r == 8'd0) || (r == 8'd1);
      volt = (w[21] | w[20]);
      nxt = 9'h0FF; rc = cmd;
      case (cmd)
        CGoIdle: if (r != 8'd1) begin phase_d = PhErr; nxt = 9'h100; end
                 else rc = CIfCond;
        CIfCond: if (r[2]) begin ver_d = 1'b0; addr_d = 1'b0; rc = COcrV1; end
                 else if (w[7:0] != 8'hAA) begin phase_d = PhErr; nxt = 9'h100; end
                 else begin ver_d = 1'b1; rc = COcrV2; end
        COcrV1, COcrV2:
                 if (r01 && !volt) begin phase_d = PhErr; nxt = 9'h100; end
                 else rc = (cmd == COcrV1) ? CAppV1 : CCrcOn;
        CAppV1:  rc = r01 ? COpV1 : CAppV1;
        COpV1:   if (r == 8'd0) begin phase_d = PhTail; nxt = 9'h0FF; res = 1'b0; end
                 else rc = CAppV1;
        CCrcOn:  rc = CAppV2;
        CAppV2:  rc = r01 ? COpV2 : CAppV2;
        COpV2:   rc = (r == 8'd0) ? CCrcOff : CAppV2;
        CCrcOff: rc = CCcs;
        default: begin
          if (r01) addr_d = w[30];
          phase_d = PhTail; res = 1'b0;
        end
      endcase
      if (nxt == 9'h100) res = 1'b0;
    end
    // Begin a new command frame
    if (res) begin
      phase_d = PhCmdBase + {rc, 2'b00}; fbi_d = 3'd0; crc_d = 8'd0; nxt = 9'h0FF;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_lim_q <= 20'd64000;
      wake_cnt_cfg_q <= 8'd10;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegReplyWait) wait_lim_q <= cfg_data_i;
      else wake_cnt_cfg_q <= cfg_data_i[7:0];
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; fbi_q <= 3'd0; poll_q <= '0; wake_q <= 8'd0;
      word_q <= 32'd0; rstat_q <= 8'hFF; crc_q <= 8'd0; ver_q <= 1'b0; addr_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d; fbi_q <= fbi_d; poll_q <= poll_d; wake_q <= wake_d;
      word_q <= word_d; rstat_q <= rstat_d; crc_q <= crc_d; ver_q <= ver_d; addr_q <= addr_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0; tx_q <= 8'd0; txv_q <= 1'b0;
    end else if (accept) begin
      ovalid_q <= 1'b1;
      txv_q <= !nxt[8];
      tx_q <= nxt[8] ? 8'd0 : nxt[7:0];
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o        = ovalid_q;
  assign tx_byte_o          = tx_q;
  assign tx_valid_o         = txv_q;
  assign finished_o         = (phase_q == PhOk) || (phase_q == PhErr);
  assign init_status_o      = (phase_q == PhErr);
  assign card_v2_o          = ver_q;
  assign block_addressing_o = addr_q;

`ifndef ASSERT_OFF
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'd0) else $error("tx byte not zero");
  a_err_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_status_o |-> finished_o) else $error("error without finish");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == OpStart |=> tx_valid_o && tx_byte_o == 8'hFF)
    else $error("start beat wrong");
`endif
endmodule
